// ----- sv/kernel_convolution_clamp_core_macros.svh -----
// assertion helpers shared by the convolution core
`ifndef KERNEL_CONVOLUTION_CLAMP_CORE_MACROS_SVH
`define KERNEL_CONVOLUTION_CLAMP_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define KCC_ASSERT_NOW(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("kcc same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define KCC_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("kcc next-cycle check failed");

`endif

// ----- sv/kcc_pkg.sv -----
package kcc_pkg;

    // defaults for top level parameters
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_PIXEL_BITS = 16;
    localparam int HEIGHT_LIMIT   = 4096;

    // port widths fixed by the register and field list
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;
    localparam int GEOM_W      = 13;
    localparam int ROW_W       = 14;
    localparam int LEVEL_W     = 16;
    localparam int WEIGHT_W    = 16;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_W_TOP    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_W_MID    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_W_BOT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DIVISOR  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_MAXLEVEL = 3'd6;

    // opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // window tap selection for one result
    typedef struct packed {
        logic [1:0] lc;
        logic [1:0] mc;
        logic [1:0] rc;
        logic [1:0] tr;
        logic [1:0] br;
    } sel_t;

endpackage

// ----- sv/kcc_arith.sv -----
module kcc_arith #(
    parameter int PIXEL_BITS = kcc_pkg::DEF_PIXEL_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  kcc_pkg::sel_t                          sel,
    input  logic [8:0][PIXEL_BITS-1:0]             win,
    input  logic [kcc_pkg::CFG_DATA_W-1:0]         weights_top,
    input  logic [kcc_pkg::CFG_DATA_W-1:0]         weights_mid,
    input  logic [kcc_pkg::CFG_DATA_W-1:0]         weights_bot,
    input  logic [kcc_pkg::WEIGHT_W-1:0]           divisor,
    input  logic [kcc_pkg::LEVEL_W-1:0]            top_level,
    output logic                                   done,
    output logic [kcc_pkg::LEVEL_W-1:0]            result
);

    localparam int PROD_W = PIXEL_BITS + kcc_pkg::WEIGHT_W + 1;
    localparam int SUM_W  = PROD_W + 4;
    localparam int NUM_W  = SUM_W + 1;
    localparam int DEN_W  = kcc_pkg::WEIGHT_W + 2;
    localparam int STEP_W = $clog2(NUM_W + 1);

    localparam logic [2:0] P_IDLE  = 3'd0;
    localparam logic [2:0] P_MAC   = 3'd1;
    localparam logic [2:0] P_SIGN  = 3'd2;
    localparam logic [2:0] P_DIV   = 3'd3;
    localparam logic [2:0] P_CLAMP = 3'd4;

    logic [2:0]                 phase_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [1:0]                 row_cnt_reg;
    logic [1:0]                 col_cnt_reg;
    kcc_pkg::sel_t              sel_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SUM_W-1:0]    acc_reg;
    logic [NUM_W-1:0]           num_reg;
    logic [DEN_W-1:0]           rem_reg;
    logic [DEN_W-1:0]           den_reg;
    logic                       neg_reg;
    logic                       done_reg;
    logic [kcc_pkg::LEVEL_W-1:0] result_reg;

    logic [1:0]                 rsel;
    logic [1:0]                 csel;
    logic [3:0]                 win_idx;
    logic [PIXEL_BITS-1:0]      pix;
    logic [kcc_pkg::CFG_DATA_W-1:0] wrow;
    logic [kcc_pkg::WEIGHT_W-1:0]   wsel;
    logic signed [PROD_W-1:0]   prod;
    logic signed [16:0]         dx;
    logic [16:0]                ad;
    logic [SUM_W-1:0]           as_mag;
    logic [DEN_W:0]             trial;

    // tap and weight for the current term
    always_comb
    begin
        case (row_cnt_reg)
            2'd0:    rsel = sel_reg.tr;
            2'd1:    rsel = 2'd1;
            default: rsel = sel_reg.br;
        endcase
        case (col_cnt_reg)
            2'd0:    csel = sel_reg.lc;
            2'd1:    csel = sel_reg.mc;
            default: csel = sel_reg.rc;
        endcase
        case (row_cnt_reg)
            2'd0:    wrow = weights_top;
            2'd1:    wrow = weights_mid;
            default: wrow = weights_bot;
        endcase
        case (col_cnt_reg)
            2'd0:    wsel = wrow[15:0];
            2'd1:    wsel = wrow[31:16];
            default: wsel = wrow[47:32];
        endcase
    end

    assign win_idx = ({2'b0, rsel} << 1) + {2'b0, rsel} + {2'b0, csel};
    assign pix     = win[win_idx];
    assign prod    = $signed(wsel) * $signed({1'b0, pix});

    // magnitudes for the divide
    assign dx     = {divisor[15], divisor};
    assign ad     = dx[16] ? 17'(-dx) : 17'(dx);
    assign as_mag = acc_reg[SUM_W-1] ? SUM_W'(-acc_reg) : SUM_W'(acc_reg);
    assign trial  = {rem_reg, num_reg[NUM_W-1]};

    // sequencer: multiply-accumulate, sign, restoring divide (skipped for a zero divisor), clamp
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                P_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= P_MAC;
                    end
                end
                P_MAC:
                begin
                    if (step_reg == STEP_W'(9))
                    begin
                        phase_reg <= P_SIGN;
                    end
                end
                P_SIGN:
                begin
                    phase_reg <= (divisor == '0) ? P_CLAMP : P_DIV;
                end
                P_DIV:
                begin
                    if (step_reg == STEP_W'(NUM_W - 1))
                    begin
                        phase_reg <= P_CLAMP;
                    end
                end
                P_CLAMP:
                begin
                    done_reg  <= 1'b1;
                    phase_reg <= P_IDLE;
                end
                default:
                begin
                    phase_reg <= P_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (phase_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    sel_reg     <= sel;
                    step_reg    <= '0;
                    row_cnt_reg <= '0;
                    col_cnt_reg <= '0;
                    acc_reg     <= '0;
                end
            end
            P_MAC:
            begin
                prod_reg <= prod;
                if (step_reg != '0)
                begin
                    acc_reg <= acc_reg + SUM_W'(prod_reg);
                end
                step_reg <= step_reg + STEP_W'(1);
                if (col_cnt_reg == 2'd2)
                begin
                    col_cnt_reg <= '0;
                    row_cnt_reg <= row_cnt_reg + 2'd1;
                end
                else
                begin
                    col_cnt_reg <= col_cnt_reg + 2'd1;
                end
            end
            P_SIGN:
            begin
                step_reg <= '0;
                rem_reg  <= '0;
                den_reg  <= {ad, 1'b0};
                if (divisor == '0)
                begin
                    neg_reg <= acc_reg[SUM_W-1];
                    num_reg <= NUM_W'(as_mag);
                end
                else
                begin
                    neg_reg <= acc_reg[SUM_W-1] ^ divisor[15];
                    num_reg <= {as_mag, 1'b0} + NUM_W'(ad);
                end
            end
            P_DIV:
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (trial >= {1'b0, den_reg})
                begin
                    rem_reg <= DEN_W'(trial - {1'b0, den_reg});
                    num_reg <= {num_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[DEN_W-1:0];
                    num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                end
            end
            P_CLAMP:
            begin
                if (neg_reg)
                begin
                    result_reg <= '0;
                end
                else if (num_reg > NUM_W'(top_level))
                begin
                    result_reg <= top_level;
                end
                else
                begin
                    result_reg <= num_reg[kcc_pkg::LEVEL_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- sv/kernel_convolution_clamp_core.sv -----
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | opcode, pixel_value
// out     | output    | out_valid / out_ready | filtered_value, frame_done
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// a pixel with a result passes accept, line store read, decode, window shift, the shared
// arithmetic unit (9 serial multiply-accumulates, sign, a 38-step restoring divide that is
// skipped with a zero divisor, clamp) and the output load; at a row start the unit runs
// before the shift; a pixel with no result due ends after the shift; past the last row
// either opcode repeats the window step until a result appears (up to width+3 steps)
// in_ready and cfg_ready are high only while the sequencer is idle; a result waits in the
// output register and the sequencer stalls while that register is full and out_ready is low
// rst_n is asynchronous; it clears control state and loads register defaults
// the line store holds no reset; its unwritten entries never reach a result
`include "kernel_convolution_clamp_core_macros.svh"

module kernel_convolution_clamp_core #(
    parameter int MAX_WIDTH  = kcc_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = kcc_pkg::DEF_PIXEL_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               opcode,
    input  logic [15:0]                        pixel_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [15:0]                        filtered_value,
    output logic                               frame_done,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [kcc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [kcc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WIDTH_W = COL_W + 1;
    localparam int ROW_W   = kcc_pkg::ROW_W;
    localparam int GEOM_W  = kcc_pkg::GEOM_W;
    localparam int TOT_W   = WIDTH_W + GEOM_W;
    localparam int PB      = PIXEL_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_CALC  = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    // configuration registers
    logic [kcc_pkg::CFG_DATA_W-1:0] w_top_reg;
    logic [kcc_pkg::CFG_DATA_W-1:0] w_mid_reg;
    logic [kcc_pkg::CFG_DATA_W-1:0] w_bot_reg;
    logic [15:0]                    divisor_reg;
    logic [GEOM_W-1:0]              width_reg;
    logic [GEOM_W-1:0]              height_reg;
    logic [15:0]                    maxlevel_reg;

    // sequencer and position state
    logic [2:0]          state_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [TOT_W-1:0]    count_reg;
    logic [WIDTH_W:0]    guard_reg;
    logic                drain_reg;
    logic                pre_reg;
    logic                got_reg;
    logic [PB-1:0]       val_reg;
    logic [15:0]         res_reg;
    kcc_pkg::sel_t       sel_reg;
    logic                start_reg;
    logic [8:0][PB-1:0]  win_reg;

    // line store: low half is the older row, high half the newer
    logic [2*PB-1:0]     line_mem [MAX_WIDTH];
    logic [2*PB-1:0]     rdata_reg;

    logic                out_valid_reg;
    logic [15:0]         out_value_reg;
    logic                out_done_reg;

    logic [WIDTH_W-1:0]  w_eff;
    logic [GEOM_W-1:0]   h_eff;
    logic [TOT_W-1:0]    total;
    logic [ROW_W-1:0]    h_row;
    logic [WIDTH_W-1:0]  col_ext;
    logic                in_frame;
    logic                pre_hit;
    logic                post_hit;
    logic                last_res;
    logic                emit_ok;
    logic                mem_we;
    logic                mem_re;
    logic [15:0]         top_level;
    logic                arith_done;
    logic [15:0]         arith_result;
    logic [2*PB-1:0]     mem_wdata;
    kcc_pkg::sel_t       sel_pre;
    kcc_pkg::sel_t       sel_post;

    // effective geometry
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WIDTH_W'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WIDTH_W'(width_reg);
        end
        if (height_reg == '0)
        begin
            h_eff = GEOM_W'(1);
        end
        else if (32'(height_reg) > kcc_pkg::HEIGHT_LIMIT)
        begin
            h_eff = GEOM_W'(kcc_pkg::HEIGHT_LIMIT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    assign total     = TOT_W'(w_eff) * TOT_W'(h_eff);
    assign h_row     = ROW_W'(h_eff);
    assign col_ext   = WIDTH_W'(col_reg);
    assign in_frame  = row_reg < h_row;
    assign last_res  = ({1'b0, count_reg} + (TOT_W+1)'(1)) >= {1'b0, total};
    assign emit_ok   = !out_valid_reg || out_ready;
    assign top_level = (32'(maxlevel_reg) > ((1 << PB) - 1)) ? 16'((1 << PB) - 1)
                                                               : maxlevel_reg;

    // result due before the shift (end of row) and after it
    assign pre_hit  = (col_reg == '0) && (row_reg >= ROW_W'(2));
    assign post_hit = (col_reg != '0) && (row_reg != '0);

    always_comb
    begin
        sel_pre.lc  = (w_eff == WIDTH_W'(1)) ? 2'd2 : 2'd1;
        sel_pre.mc  = 2'd2;
        sel_pre.rc  = 2'd2;
        sel_pre.tr  = (row_reg == ROW_W'(2)) ? 2'd1 : 2'd0;
        sel_pre.br  = (row_reg > h_row) ? 2'd1 : 2'd2;
        sel_post.lc = (col_reg == COL_W'(1)) ? 2'd1 : 2'd0;
        sel_post.mc = 2'd1;
        sel_post.rc = (col_ext >= w_eff) ? 2'd1 : 2'd2;
        sel_post.tr = (row_reg == ROW_W'(1)) ? 2'd1 : 2'd0;
        sel_post.br = (row_reg >= h_row) ? 2'd1 : 2'd2;
    end

    assign mem_re    = (state_reg == S_RD);
    assign mem_we    = (state_reg == S_SHIFT);
    assign mem_wdata = {val_reg, rdata_reg[2*PB-1:PB]};

    // line store port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[col_reg] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= line_mem[col_reg];
        end
    end

    // shared arithmetic unit
    kcc_arith #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_arith (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start_reg),
        .sel         (sel_reg),
        .win         (win_reg),
        .weights_top (w_top_reg),
        .weights_mid (w_mid_reg),
        .weights_bot (w_bot_reg),
        .divisor     (divisor_reg),
        .top_level   (top_level),
        .done        (arith_done),
        .result      (arith_result)
    );

    // configuration, sequencer and window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_top_reg     <= '0;
            w_mid_reg     <= 48'h10000;
            w_bot_reg     <= '0;
            divisor_reg   <= 16'd1;
            width_reg     <= GEOM_W'(4096);
            height_reg    <= GEOM_W'(4096);
            maxlevel_reg  <= 16'd255;
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            count_reg     <= '0;
            guard_reg     <= '0;
            drain_reg     <= 1'b0;
            pre_reg       <= 1'b0;
            got_reg       <= 1'b0;
            val_reg       <= '0;
            res_reg       <= '0;
            sel_reg       <= '0;
            start_reg     <= 1'b0;
            win_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_done_reg  <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        got_reg   <= 1'b0;
                        guard_reg <= '0;
                        if (opcode == kcc_pkg::OP_PIXEL && in_frame)
                        begin
                            drain_reg <= 1'b0;
                            val_reg   <= pixel_value[PB-1:0];
                            state_reg <= S_RD;
                        end
                        else if (!in_frame)
                        begin
                            drain_reg <= 1'b1;
                            val_reg   <= '0;
                            state_reg <= S_RD;
                        end
                    end
                end
                S_RD:
                begin
                    pre_reg   <= pre_hit;
                    state_reg <= S_DEC;
                end
                S_DEC:
                begin
                    if (pre_reg)
                    begin
                        sel_reg   <= sel_pre;
                        start_reg <= 1'b1;
                        state_reg <= S_CALC;
                    end
                    else
                    begin
                        state_reg <= S_SHIFT;
                    end
                end
                S_CALC:
                begin
                    if (arith_done)
                    begin
                        res_reg <= arith_result;
                        if (pre_reg)
                        begin
                            got_reg   <= 1'b1;
                            pre_reg   <= 1'b0;
                            state_reg <= S_SHIFT;
                        end
                        else
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_SHIFT:
                begin
                    // window moves one column, new column from the line store and the input pixel
                    for (int i = 0; i < 3; i++)
                    begin
                        win_reg[i*3]     <= win_reg[i*3 + 1];
                        win_reg[i*3 + 1] <= win_reg[i*3 + 2];
                    end
                    win_reg[2] <= rdata_reg[PB-1:0];
                    win_reg[5] <= rdata_reg[2*PB-1:PB];
                    win_reg[8] <= val_reg;
                    if ((col_ext + WIDTH_W'(1)) >= w_eff)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        col_reg <= col_reg + COL_W'(1);
                    end
                    if (post_hit)
                    begin
                        sel_reg   <= sel_post;
                        start_reg <= 1'b1;
                        state_reg <= S_CALC;
                    end
                    else if (got_reg)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else if (drain_reg &&
                             (guard_reg + (WIDTH_W+1)'(1)) < ({1'b0, w_eff} + (WIDTH_W+1)'(3)))
                    begin
                        guard_reg <= guard_reg + (WIDTH_W+1)'(1);
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_EMIT:
                begin
                    if (emit_ok)
                    begin
                        out_valid_reg <= 1'b1;
                        out_value_reg <= res_reg;
                        out_done_reg  <= last_res;
                        if (last_res)
                        begin
                            count_reg <= '0;
                            col_reg   <= '0;
                            row_reg   <= '0;
                        end
                        else
                        begin
                            count_reg <= count_reg + TOT_W'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // register write transaction
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    kcc_pkg::REG_W_TOP:    w_top_reg    <= cfg_data;
                    kcc_pkg::REG_W_MID:    w_mid_reg    <= cfg_data;
                    kcc_pkg::REG_W_BOT:    w_bot_reg    <= cfg_data;
                    kcc_pkg::REG_DIVISOR:  divisor_reg  <= cfg_data[15:0];
                    kcc_pkg::REG_WIDTH:
                    begin
                        width_reg <= cfg_data[GEOM_W-1:0];
                        col_reg   <= '0;
                        row_reg   <= '0;
                        count_reg <= '0;
                    end
                    kcc_pkg::REG_HEIGHT:
                    begin
                        height_reg <= cfg_data[GEOM_W-1:0];
                        col_reg    <= '0;
                        row_reg    <= '0;
                        count_reg  <= '0;
                    end
                    kcc_pkg::REG_MAXLEVEL: maxlevel_reg <= cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign cfg_ready      = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign filtered_value = out_value_reg;
    assign frame_done     = out_done_reg;

    // checks
    `KCC_ASSERT_NOW(a_done_in_calc, arith_done, state_reg == S_CALC)
    `KCC_ASSERT_NEXT(a_pixel_reads, in_valid && in_ready && opcode == kcc_pkg::OP_PIXEL && in_frame, state_reg == S_RD)
    `KCC_ASSERT_NOW(a_col_in_row, state_reg == S_IDLE, col_ext < w_eff)

endmodule
